FILE: hw/rtl/rgb_box_downsampler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box downsampler
// Shared implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_DOWNSAMPLER_ASSERT_SVH
`define RGB_BOX_DOWNSAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBBD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgbbd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RGBBD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgbbd assertion failed");

`endif

FILE: hw/rtl/rgbbd_pkg.sv
// ----------------------------------------------------------------------------
// rgbbd_pkg
// Constants, types and controller codes of the RGB box downsampler.
// ----------------------------------------------------------------------------
package rgbbd_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_RATE   = 16;
   localparam int CH         = 3;
   localparam int PIX_W      = 8;
   localparam int IMG_W      = 12;
   localparam int RATE_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int COL_W      = $clog2(MAX_WIDTH) + 1;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int SUB_W      = $clog2(MAX_RATE);
   localparam int SUM_W      = $clog2(MAX_RATE * MAX_WIDTH * 255 + 1);
   localparam int DIV_W      = $clog2(MAX_RATE * MAX_RATE + 1);
   localparam int STEP_W     = $clog2(SUM_W);

   typedef logic [CH-1:0][SUM_W-1:0] sum_vec_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH = 2'd0,
      CSR_X_RATE      = 2'd1,
      CSR_Y_RATE      = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVW,
      ST_MUL,
      ST_ADD,
      ST_RMW,
      ST_DIVA,
      ST_EMIT,
      ST_POST
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic start_w;
      logic load_lim;
      logic do_add;
      logic do_rmw;
      logic start_s;
      logic load_rsp;
      logic do_post;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic blk_full;
      logic emit;
      logic rsp_free;
   } dp_stat_type;

endpackage

FILE: hw/rtl/rgbbd_req_if.sv
// ----------------------------------------------------------------------------
// rgbbd_req_if
// Pixel input channel: valid/ready handshake with an RGB pixel payload.
// ----------------------------------------------------------------------------
interface rgbbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_start;

   modport source (output valid, output red, output green, output blue,
                   output frame_start, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input frame_start, output ready);
endinterface

FILE: hw/rtl/rgbbd_rsp_if.sv
// ----------------------------------------------------------------------------
// rgbbd_rsp_if
// Result channel: valid/ready handshake with the block averages.
// ----------------------------------------------------------------------------
interface rgbbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] avg_red;
   logic [7:0] avg_green;
   logic [7:0] avg_blue;
   logic       row_end;

   modport source (output valid, output avg_red, output avg_green, output avg_blue,
                   output row_end, input ready);
   modport sink   (input valid, input avg_red, input avg_green, input avg_blue,
                   input row_end, output ready);
endinterface

FILE: hw/rtl/rgbbd_div.sv
// ----------------------------------------------------------------------------
// rgbbd_div
// Three-lane restoring divider sharing one divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rgbbd_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  rgbbd_pkg::sum_vec_type               dividend,
   input  logic [rgbbd_pkg::DIV_W-1:0]          divisor,
   output rgbbd_pkg::sum_vec_type               quotient,
   output logic                                 done
);
   import rgbbd_pkg::*;

   sum_vec_type              quo_ff, quo_in;
   logic [CH-1:0][DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]         den_ff;
   logic [STEP_W-1:0]        cnt_ff;
   logic                     busy_ff;
   logic                     done_ff;

   always_comb begin
      logic [DIV_W:0] trial;
      for (int c = 0; c < CH; c++) begin
         trial = {rem_ff[c], quo_ff[c][SUM_W-1]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in[c] = DIV_W'(trial - {1'b0, den_ff});
            quo_in[c] = {quo_ff[c][SUM_W-2:0], 1'b1};
         end else begin
            rem_in[c] = trial[DIV_W-1:0];
            quo_in[c] = {quo_ff[c][SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEP_W'(SUM_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

FILE: hw/rtl/rgbbd_dpath.sv
// ----------------------------------------------------------------------------
// rgbbd_dpath
// Registers, counters, column sum memory, divider and result register.
// ----------------------------------------------------------------------------
module rgbbd_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rgbbd_pkg::dp_cmd_type                cmd,
   output rgbbd_pkg::dp_stat_type               stat,
   input  logic                                 csr_wr_en,
   input  logic [rgbbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rgbbd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [7:0]                           req_red,
   input  logic [7:0]                           req_green,
   input  logic [7:0]                           req_blue,
   input  logic                                 req_frame_start,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [7:0]                           rsp_avg_red,
   output logic [7:0]                           rsp_avg_green,
   output logic [7:0]                           rsp_avg_blue,
   output logic                                 rsp_row_end
);
   import rgbbd_pkg::*;

   logic [IMG_W-1:0]  img_width_ff;
   logic [RATE_W-1:0] x_rate_ff;
   logic [RATE_W-1:0] y_rate_ff;

   logic [COL_W-1:0]  w_eff;
   logic [RATE_W-1:0] xr_eff;
   logic [RATE_W-1:0] yr_eff;

   logic [CH-1:0][PIX_W-1:0] pix_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [SUB_W-1:0]  subx_ff, subx_in;
   logic [SUB_W-1:0]  suby_ff, suby_in;
   logic [COL_W-1:0]  oc_ff, oc_in;
   sum_vec_type       part_ff, part_in;
   logic [COL_W-1:0]  nblk_ff;
   logic [COL_W-1:0]  lim_ff;
   sum_vec_type       rd_ff;
   logic              row_end_ff;

   sum_vec_type       mem [MAX_WIDTH];

   logic [ADDR_W-1:0] oc_addr;
   logic              in_blk;
   logic [SUB_W:0]    subx_inc;
   logic [SUB_W:0]    suby_inc;
   sum_vec_type       new_sum;
   sum_vec_type       div_a;
   logic [DIV_W-1:0]  div_b;
   sum_vec_type       div_q;
   logic              div_done;

   logic              rsp_valid_ff;
   logic [CH-1:0][PIX_W-1:0] avg_ff;
   logic              rsp_row_end_ff;

   // Configuration registers; values out of range are clamped on use.
   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff <= IMG_W'(640);
         x_rate_ff    <= RATE_W'(1);
         y_rate_ff    <= RATE_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: img_width_ff <= csr_wdata[IMG_W-1:0];
            CSR_X_RATE:      x_rate_ff    <= csr_wdata[RATE_W-1:0];
            CSR_Y_RATE:      y_rate_ff    <= csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (img_width_ff == '0) w_eff = COL_W'(1);
      else if (int'(img_width_ff) > MAX_WIDTH) w_eff = COL_W'(MAX_WIDTH);
      else w_eff = COL_W'(img_width_ff);
      if (x_rate_ff == '0) xr_eff = RATE_W'(1);
      else if (int'(x_rate_ff) > MAX_RATE) xr_eff = RATE_W'(MAX_RATE);
      else xr_eff = x_rate_ff;
      if (y_rate_ff == '0) yr_eff = RATE_W'(1);
      else if (int'(y_rate_ff) > MAX_RATE) yr_eff = RATE_W'(MAX_RATE);
      else yr_eff = y_rate_ff;
   end

   assign oc_addr  = (int'(oc_ff) > MAX_WIDTH - 1) ? ADDR_W'(MAX_WIDTH - 1)
                                                  : oc_ff[ADDR_W-1:0];
   assign in_blk   = col_ff < lim_ff;
   assign subx_inc = {1'b0, subx_ff} + 1'b1;
   assign suby_inc = {1'b0, suby_ff} + 1'b1;

   always_comb begin
      for (int c = 0; c < CH; c++) begin
         if (suby_ff == '0) new_sum[c] = part_ff[c];
         else new_sum[c] = rd_ff[c] + part_ff[c];
      end
   end

   // Counter and partial sum updates, one command at a time.
   always_comb begin
      logic [SUB_W:0] sy;
      col_in  = col_ff;
      subx_in = subx_ff;
      suby_in = suby_ff;
      oc_in   = oc_ff;
      part_in = part_ff;
      sy      = {1'b0, suby_ff};
      if (cmd.accept) begin
         if (req_frame_start) begin
            col_in  = '0;
            subx_in = '0;
            oc_in   = '0;
            part_in = '0;
            sy      = '0;
         end
         if (col_in >= w_eff) begin
            col_in  = '0;
            subx_in = '0;
            oc_in   = '0;
            part_in = '0;
            sy      = sy + 1'b1;
         end
         if (sy >= (SUB_W+1)'(yr_eff)) sy = '0;
         if ((SUB_W+1)'(subx_in) >= (SUB_W+1)'(xr_eff)) subx_in = '0;
         suby_in = sy[SUB_W-1:0];
      end else if (cmd.do_add) begin
         if (in_blk) begin
            for (int c = 0; c < CH; c++) begin
               part_in[c] = part_ff[c] + SUM_W'(pix_ff[c]);
            end
            if (subx_inc >= (SUB_W+1)'(xr_eff)) subx_in = '0;
            else subx_in = subx_inc[SUB_W-1:0];
         end
      end else if (cmd.do_rmw) begin
         part_in = '0;
         oc_in   = oc_ff + 1'b1;
      end else if (cmd.do_post) begin
         col_in = col_ff + 1'b1;
         if (col_in >= w_eff) begin
            col_in  = '0;
            subx_in = '0;
            oc_in   = '0;
            part_in = '0;
            sy      = suby_inc;
            if (sy >= (SUB_W+1)'(yr_eff)) sy = '0;
            suby_in = sy[SUB_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         subx_ff <= '0;
         suby_ff <= '0;
         oc_ff   <= '0;
         part_ff <= '0;
      end else begin
         col_ff  <= col_in;
         subx_ff <= subx_in;
         suby_ff <= suby_in;
         oc_ff   <= oc_in;
         part_ff <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) pix_ff <= {req_blue, req_green, req_red};
      if (cmd.load_lim) begin
         nblk_ff <= div_q[0][COL_W-1:0];
         lim_ff  <= COL_W'(div_q[0][COL_W-1:0] * xr_eff);
      end
      if (cmd.do_rmw) row_end_ff <= ({1'b0, oc_ff} + 1'b1) >= {1'b0, nblk_ff};
   end

   // Column sum memory: read while the pixel is added, written back next cycle.
   always_ff @(posedge clock) begin
      if (cmd.do_add) rd_ff <= mem[oc_addr];
      if (cmd.do_rmw) mem[oc_addr] <= new_sum;
   end

   always_comb begin
      if (cmd.start_w) begin
         for (int c = 0; c < CH; c++) div_a[c] = SUM_W'(w_eff);
         div_b = DIV_W'(xr_eff);
      end else begin
         div_a = new_sum;
         div_b = DIV_W'(xr_eff) * DIV_W'(yr_eff);
      end
   end

   rgbbd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_w | cmd.start_s),
      .dividend (div_a),
      .divisor  (div_b),
      .quotient (div_q),
      .done     (div_done)
   );

   // Result register; it frees as soon as the consumer takes the transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         for (int c = 0; c < CH; c++) begin
            avg_ff[c] <= (div_q[c] > SUM_W'(255)) ? PIX_W'(255) : div_q[c][PIX_W-1:0];
         end
         rsp_row_end_ff <= row_end_ff;
      end
   end

   assign stat.div_done = div_done;
   assign stat.blk_full = in_blk && (subx_inc >= (SUB_W+1)'(xr_eff));
   assign stat.emit     = suby_inc >= (SUB_W+1)'(yr_eff);
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_avg_red   = avg_ff[0];
   assign rsp_avg_green = avg_ff[1];
   assign rsp_avg_blue  = avg_ff[2];
   assign rsp_row_end   = rsp_row_end_ff;

endmodule

FILE: hw/rtl/rgbbd_ctrl.sv
// ----------------------------------------------------------------------------
// rgbbd_ctrl
// Sequencer that steps one pixel through the datapath.
// ----------------------------------------------------------------------------
module rgbbd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output rgbbd_pkg::dp_cmd_type   cmd,
   input  rgbbd_pkg::dp_stat_type  stat
);
   import rgbbd_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DIVW;
         ST_DIVW: if (stat.div_done) state_in = ST_MUL;
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  state_in = stat.blk_full ? ST_RMW : ST_POST;
         ST_RMW:  state_in = stat.emit ? ST_DIVA : ST_POST;
         ST_DIVA: if (stat.div_done) state_in = ST_EMIT;
         ST_EMIT: if (stat.rsp_free) state_in = ST_POST;
         ST_POST: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.accept  = req_valid;
            cmd.start_w = req_valid;
         end
         ST_MUL:  cmd.load_lim = 1'b1;
         ST_ADD:  cmd.do_add = 1'b1;
         ST_RMW: begin
            cmd.do_rmw  = 1'b1;
            cmd.start_s = stat.emit;
         end
         ST_EMIT: cmd.load_rsp = stat.rsp_free;
         ST_POST: cmd.do_post = 1'b1;
         default: ;
      endcase
   end

endmodule

FILE: hw/rtl/rgb_box_downsampler.sv
// The block takes a new pixel only once the last has left the sequencer. Each pixel
// passes IDLE, DIVW, MUL, ADD and POST; one that fills a block's strip adds RMW, and one
// that completes a block also passes DIVA and EMIT. The 23-step shared divider runs
// once for the blocks per row, once more for the three block averages. A pending result
// stalls only a pixel that completes the next block, until the result register frees.
// Synchronous reset idles the sequencer, empties the result register, zeroes the
// counters and restores width 640 and rates of 1; column sums are not cleared.
// ----------------------------------------------------------------------------
// rgb_box_downsampler
// Box-filter downsampler of a raster RGB pixel stream.
// ----------------------------------------------------------------------------
module rgb_box_downsampler (
   input  logic                                 clock,
   input  logic                                 reset,
   rgbbd_req_if.sink                            req_ch,
   rgbbd_rsp_if.source                          rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [rgbbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rgbbd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rgbbd_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   rgbbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rgbbd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_red         (req_ch.red),
      .req_green       (req_ch.green),
      .req_blue        (req_ch.blue),
      .req_frame_start (req_ch.frame_start),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_avg_red     (rsp_ch.avg_red),
      .rsp_avg_green   (rsp_ch.avg_green),
      .rsp_avg_blue    (rsp_ch.avg_blue),
      .rsp_row_end     (rsp_ch.row_end)
   );

endmodule

FILE: hw/rtl/rgbbd_checker.sv
// ----------------------------------------------------------------------------
// rgbbd_checker
// Port-level checks of the box downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_box_downsampler_assert.svh"

module rgbbd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // A stalled result transaction stays offered.
   `RGBBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Reset empties the result register.
   `RGBBD_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

   // Pixels are processed one at a time, so input closes after an acceptance.
   `RGBBD_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && req_ready, !req_ready)

   // A new result is only produced while a pixel is still being finished.
   `RGBBD_ASSERT_NOW(a_rsp_rise, clock, reset, rsp_valid && !$past(rsp_valid), !req_ready)

endmodule

bind rgb_box_downsampler rgbbd_checker u_rgbbd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Box downsampler testbench
// Streams RGB pixels through several width and block-size settings, predicts
// each block average with its own model of the column sums, and compares
// every result transaction with the oldest prediction. Both channels stall
// at random for most of the run.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rgbbd_pkg::*;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
   } block_avg_type;

   class block_avg_scoreboard;
      int unsigned   img_width;
      int unsigned   x_size;
      int unsigned   y_size;
      int unsigned   col_sum[MAX_WIDTH][3];
      int unsigned   col_pos;
      int unsigned   x_count;
      int unsigned   y_count;
      int unsigned   out_col;
      int unsigned   strip_sum[3];
      block_avg_type avg_queue[$];
      int            mismatches;
      int            results_seen;

      function void init();
         img_width = 640;
         x_size = 1;
         y_size = 1;
         foreach (col_sum[i, c]) col_sum[i][c] = 0;
         new_row();
         y_count = 0;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void new_row();
         col_pos = 0;
         x_count = 0;
         out_col = 0;
         for (int c = 0; c < 3; c++) strip_sum[c] = 0;
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
         return (v < lo) ? lo : (v > hi) ? hi : v;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_IMAGE_WIDTH: img_width = 32'(val);
            CSR_X_RATE:      x_size = 32'(val[RATE_W-1:0]);
            CSR_Y_RATE:      y_size = 32'(val[RATE_W-1:0]);
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
         int unsigned   w, xr, yr, nblk, oc, n, a;
         int unsigned   pix[3];
         block_avg_type res;
         w = clamp(img_width, 1, MAX_WIDTH);
         xr = clamp(x_size, 1, MAX_RATE);
         yr = clamp(y_size, 1, MAX_RATE);
         nblk = w / xr;
         pix[0] = r;
         pix[1] = g;
         pix[2] = b;
         if (fs) begin
            new_row();
            y_count = 0;
         end
         if (col_pos >= w) begin
            new_row();
            y_count++;
         end
         if (y_count >= yr) y_count = 0;
         if (x_count >= xr) x_count = 0;
         // Pixels past the last whole block of a row are ignored.
         if (col_pos < nblk * xr) begin
            for (int c = 0; c < 3; c++) strip_sum[c] += pix[c];
            x_count++;
            if (x_count >= xr) begin
               oc = (out_col < MAX_WIDTH) ? out_col : MAX_WIDTH - 1;
               x_count = 0;
               for (int c = 0; c < 3; c++) begin
                  if (y_count == 0) col_sum[oc][c] = strip_sum[c];
                  else col_sum[oc][c] += strip_sum[c];
                  strip_sum[c] = 0;
               end
               if (y_count + 1 >= yr) begin
                  n = xr * yr;
                  a = col_sum[oc][0] / n;
                  res.red = (a > 255) ? 8'd255 : a[7:0];
                  a = col_sum[oc][1] / n;
                  res.green = (a > 255) ? 8'd255 : a[7:0];
                  a = col_sum[oc][2] / n;
                  res.blue = (a > 255) ? 8'd255 : a[7:0];
                  res.row_end = (out_col + 1 >= nblk);
                  avg_queue.push_back(res);
               end
               out_col++;
            end
         end
         col_pos++;
         if (col_pos >= w) begin
            new_row();
            y_count++;
            if (y_count >= yr) y_count = 0;
         end
      endfunction

      function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic re);
         block_avg_type exp_avg;
         results_seen++;
         if (avg_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0b",
                     $time, r, g, b, re);
            mismatches++;
            return;
         end
         exp_avg = avg_queue.pop_front();
         if (r !== exp_avg.red) begin
            $display("%0t: avg_red expected %0d actual %0d", $time, exp_avg.red, r);
            mismatches++;
         end
         if (g !== exp_avg.green) begin
            $display("%0t: avg_green expected %0d actual %0d", $time, exp_avg.green, g);
            mismatches++;
         end
         if (b !== exp_avg.blue) begin
            $display("%0t: avg_blue expected %0d actual %0d", $time, exp_avg.blue, b);
            mismatches++;
         end
         if (re !== exp_avg.row_end) begin
            $display("%0t: row_end expected %0b actual %0b", $time, exp_avg.row_end, re);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rgbbd_req_if req_ch ();
   rgbbd_rsp_if rsp_ch ();

   rgb_box_downsampler uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   block_avg_scoreboard scb;
   bit quiet = 1'b0;
   int pixels_sent = 0;
   int phases_run = 0;
   int stall_left = 0;

   always #10 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.red = '0;
      req_ch.green = '0;
      req_ch.blue = '0;
      req_ch.frame_start = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   // Result side: random stall bursts until the quiet tail of the run.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         scb.check_result(rsp_ch.avg_red, rsp_ch.avg_green, rsp_ch.avg_blue, rsp_ch.row_end);
   end

   // Leaves the write enable high; the caller drops it after its last write.
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      scb.write_reg(idx, val);
   endtask

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.red <= r;
      req_ch.green <= g;
      req_ch.blue <= b;
      req_ch.frame_start <= fs;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      scb.note_pixel(r, g, b, fs);
      pixels_sent++;
   endtask

   // Waits until every predicted transaction has arrived, then lets a
   // pixel that completes no block drain out of the sequencer.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (scb.avg_queue.size() > 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_phase(int unsigned w, int unsigned xr, int unsigned yr, int n);
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_X_RATE, CSR_DATA_W'(xr));
      write_csr(CSR_Y_RATE, CSR_DATA_W'(yr));
      csr_wr_en <= 1'b0;
      phases_run++;
      for (int i = 0; i < n; i++) begin
         if (pixels_sent > 740) quiet = 1'b1;
         send_pixel(rand_chan(), rand_chan(), rand_chan(),
                    (i == 0) || ($urandom_range(0, 60) == 0));
      end
      drain();
   endtask

   initial begin
      int unsigned w, xr, yr;
      scb = new();
      scb.init();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings and no frame start yet: counters run from reset.
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd170, 1'b0);
      send_pixel(8'd85, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd1, 8'd128, 8'd254, 1'b1);
      drain();

      // Saturated full blocks, widths and rates outside the legal range.
      run_phase(4, 2, 2, 12);
      run_phase(0, 1, 16, 20);
      run_phase(12'hFFF, 31, 0, 40);
      run_phase(2048, 16, 1, 40);
      run_phase(7, 3, 2, 30);
      run_phase(16, 16, 16, 260);

      while (pixels_sent < 780) begin
         w = $urandom_range(1, 24);
         xr = $urandom_range(1, 8);
         yr = $urandom_range(1, 4);
         run_phase(w, xr, yr, $urandom_range(40, 120));
      end

      $display("Sent %0d pixels over %0d register settings; %0d block averages checked.",
               pixels_sent, phases_run, scb.results_seen);
      if (scb.mismatches == 0 && scb.avg_queue.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timed out with %0d transactions outstanding.", scb.avg_queue.size());
      $display("Mismatches found");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rgbbd_pkg.sv
hw/rtl/rgbbd_req_if.sv
hw/rtl/rgbbd_rsp_if.sv
hw/rtl/rgbbd_div.sv
hw/rtl/rgbbd_dpath.sv
hw/rtl/rgbbd_ctrl.sv
hw/rtl/rgb_box_downsampler.sv
hw/rtl/rgbbd_checker.sv
test/tb.sv
